@@ rtl/core/prtt_pkg.sv @@
// ----------------------------------------------------------------------------
// prtt_pkg
// shared types, codes and constants of the pending request timeout table
// ----------------------------------------------------------------------------
package prtt_pkg;

  localparam int unsigned TABLE_DEPTH   = 16;
  localparam logic [15:0] RESET_TIMEOUT = 16'd120;

  // request operations
  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_GET  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  typedef enum logic [2:0] {
    CODE_OK        = 3'd0,
    CODE_NOT_FOUND = 3'd1,
    CODE_FULL      = 3'd2,
    CODE_TIMED_OUT = 3'd3,
    CODE_FORCED    = 3'd4,
    CODE_DONE      = 3'd5
  } code_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_REPLY
  } state_e;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] handle;
    logic [31:0] start;
    logic [15:0] limit;
    logic        early;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;      // latch request beat, restart scan
    logic probe;        // read slot at scan index
    logic check;        // compare key of slot just read
    logic next;         // advance scan index
    logic emit_expire;  // load expiry result into output register
    logic emit_final;   // load closing result into output register
    logic drop;         // free slot at scan index
    logic commit;       // apply set or get to the table
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       cur_valid;
    logic       idx_last;
    logic       expire;
    logic       out_free;
  } dp_status_t;

endpackage

@@ rtl/core/prtt_if.sv @@
// ----------------------------------------------------------------------------
// prtt channel interfaces
// request, response and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface prtt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] flow;
  logic [31:0] handle;
  logic [31:0] entry_start;
  logic [15:0] entry_timeout;
  logic        early_enable;
  logic [31:0] now;

  modport source (
    output valid, op, flow, handle, entry_start, entry_timeout, early_enable, now,
    input  ready
  );
  modport sink (
    input  valid, op, flow, handle, entry_start, entry_timeout, early_enable, now,
    output ready
  );
endinterface

interface prtt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  code;
  logic [31:0] result_flow;
  logic [31:0] result_handle;
  logic        last;

  modport source (
    output valid, code, result_flow, result_handle, last,
    input  ready
  );
  modport sink (
    input  valid, code, result_flow, result_handle, last,
    output ready
  );
endinterface

interface prtt_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

@@ rtl/core/prtt_datapath.sv @@
// ----------------------------------------------------------------------------
// prtt_datapath
// entry memory, valid bits, scan index, expiry compare and output register
// ----------------------------------------------------------------------------
module prtt_datapath #(
  parameter int unsigned TableDepth = prtt_pkg::TABLE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  prtt_pkg::dp_cmd_t    cmd_i,
  output prtt_pkg::dp_status_t status_o,
  input  logic [1:0]           op_i,
  input  logic [31:0]          flow_i,
  input  logic [31:0]          handle_i,
  input  logic [31:0]          entry_start_i,
  input  logic [15:0]          entry_timeout_i,
  input  logic                 early_enable_i,
  input  logic [31:0]          now_i,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           code_o,
  output logic [31:0]          result_flow_o,
  output logic [31:0]          result_handle_o,
  output logic                 last_o
);
  import prtt_pkg::*;

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(TableDepth - 1);

  entry_t entry_mem [TableDepth];
  entry_t rd_q;

  // control state
  logic [TableDepth-1:0] valid_q, valid_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic                  hit_q, hit_d;
  logic                  free_q, free_d;
  logic                  out_valid_q, out_valid_d;
  logic [15:0]           default_q, default_d;

  // payload
  logic [1:0]      op_q;
  logic [31:0]     flow_q, handle_q, start_q, now_q;
  logic [15:0]     timeout_q;
  logic            early_q;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  logic [31:0]     hit_handle_q, hit_handle_d;
  logic [2:0]      out_code_q;
  logic [31:0]     out_flow_q, out_handle_q;
  logic            out_last_q;

  logic [31:0]     elapsed;
  logic            timed_out, forced;
  logic [IdxW-1:0] slot;
  logic            mem_we;
  entry_t          wr_entry;
  code_e           final_code;
  logic [31:0]     final_flow, final_handle;

  // elapsed time wraps at 2^32
  assign elapsed   = now_q - rd_q.start;
  assign timed_out = elapsed > {15'd0, rd_q.limit, 1'b0};
  assign forced    = (elapsed > {16'd0, rd_q.limit}) && rd_q.early;

  assign slot   = hit_q ? hit_idx_q : free_idx_q;
  assign mem_we = cmd_i.commit && (op_q == OP_SET) && (hit_q || free_q);

  always_comb begin
    wr_entry.key    = flow_q;
    wr_entry.handle = handle_q;
    wr_entry.start  = start_q;
    wr_entry.limit  = (timeout_q == 16'd0) ? default_q : timeout_q;
    wr_entry.early  = early_q;
  end

  always_comb begin
    final_code   = CODE_OK;
    final_flow   = 32'd0;
    final_handle = 32'd0;
    case (op_q)
      OP_SET: begin
        final_code   = (hit_q || free_q) ? CODE_OK : CODE_FULL;
        final_flow   = flow_q;
        final_handle = handle_q;
      end
      OP_GET: begin
        final_code   = hit_q ? CODE_OK : CODE_NOT_FOUND;
        final_flow   = flow_q;
        final_handle = hit_q ? hit_handle_q : 32'd0;
      end
      OP_TICK: begin
        final_code = CODE_DONE;
      end
      default: begin
        final_code = CODE_OK;
      end
    endcase
  end

  always_comb begin
    valid_d      = valid_q;
    idx_d        = idx_q;
    hit_d        = hit_q;
    free_d       = free_q;
    hit_idx_d    = hit_idx_q;
    free_idx_d   = free_idx_q;
    hit_handle_d = hit_handle_q;
    default_d    = cfg_we_i ? cfg_data_i : default_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    if (cmd_i.capture) begin
      idx_d  = '0;
      hit_d  = 1'b0;
      free_d = 1'b0;
    end
    if (cmd_i.probe && !valid_q[idx_q] && !free_q) begin
      free_d     = 1'b1;
      free_idx_d = idx_q;
    end
    if (cmd_i.check && (rd_q.key == flow_q) && !hit_q) begin
      hit_d        = 1'b1;
      hit_idx_d    = idx_q;
      hit_handle_d = rd_q.handle;
    end
    if (cmd_i.next) begin
      idx_d = idx_q + 1'b1;
    end
    if (cmd_i.drop) begin
      valid_d[idx_q] = 1'b0;
    end
    if (mem_we) begin
      valid_d[slot] = 1'b1;
    end
    if (cmd_i.commit && (op_q == OP_GET) && hit_q) begin
      valid_d[hit_idx_q] = 1'b0;
    end
    if (cmd_i.emit_expire || cmd_i.emit_final) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
      default_q   <= RESET_TIMEOUT;
    end else begin
      valid_q     <= valid_d;
      idx_q       <= idx_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
      default_q   <= default_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q    <= hit_idx_d;
    free_idx_q   <= free_idx_d;
    hit_handle_q <= hit_handle_d;
    if (cmd_i.capture) begin
      op_q      <= op_i;
      flow_q    <= flow_i;
      handle_q  <= handle_i;
      start_q   <= entry_start_i;
      timeout_q <= entry_timeout_i;
      early_q   <= early_enable_i;
      now_q     <= now_i;
    end
    if (cmd_i.emit_expire) begin
      out_code_q   <= timed_out ? CODE_TIMED_OUT : CODE_FORCED;
      out_flow_q   <= rd_q.key;
      out_handle_q <= rd_q.handle;
      out_last_q   <= 1'b0;
    end else if (cmd_i.emit_final) begin
      out_code_q   <= final_code;
      out_flow_q   <= final_flow;
      out_handle_q <= final_handle;
      out_last_q   <= 1'b1;
    end
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[slot] <= wr_entry;
    end
    if (cmd_i.probe) begin
      rd_q <= entry_mem[idx_q];
    end
  end

  always_comb begin
    status_o.op        = op_q;
    status_o.cur_valid = valid_q[idx_q];
    status_o.idx_last  = (idx_q == IdxLast);
    status_o.expire    = timed_out || forced;
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o     = out_valid_q;
  assign code_o          = out_code_q;
  assign result_flow_o   = out_flow_q;
  assign result_handle_o = out_handle_q;
  assign last_o          = out_last_q;

endmodule

@@ rtl/core/prtt_ctrl.sv @@
// ----------------------------------------------------------------------------
// prtt_ctrl
// sequencer for the slot scan of set, get and tick requests
// ----------------------------------------------------------------------------
module prtt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  prtt_pkg::dp_status_t status_i,
  output prtt_pkg::dp_cmd_t    cmd_o
);
  import prtt_pkg::*;

  state_e state_q, state_d;
  logic   is_lookup, is_tick;

  assign is_lookup = (status_i.op == OP_SET) || (status_i.op == OP_GET);
  assign is_tick   = (status_i.op == OP_TICK);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (status_i.cur_valid) begin
          state_d = ST_EVAL;
        end else if (status_i.idx_last) begin
          state_d = ST_REPLY;
        end
      end
      ST_EVAL: begin
        if (!(is_tick && status_i.expire && !status_i.out_free)) begin
          state_d = status_i.idx_last ? ST_REPLY : ST_READ;
        end
      end
      ST_REPLY: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_READ: begin
        cmd_o.probe = 1'b1;
        cmd_o.next  = !status_i.cur_valid && !status_i.idx_last;
      end
      ST_EVAL: begin
        cmd_o.check = is_lookup;
        if (is_tick && status_i.expire) begin
          cmd_o.emit_expire = status_i.out_free;
          cmd_o.drop        = status_i.out_free;
          cmd_o.next        = status_i.out_free && !status_i.idx_last;
        end else begin
          cmd_o.next = !status_i.idx_last;
        end
      end
      ST_REPLY: begin
        cmd_o.emit_final = status_i.out_free;
        cmd_o.commit     = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/pending_request_timeout_table.sv @@
// ----------------------------------------------------------------------------
// pending_request_timeout_table
// table of pending requests keyed by flow id, with lookup and timeout scan
// ----------------------------------------------------------------------------
// Each request beat is handled by one pass over all TableDepth slots. A free
// slot is passed in the read state alone, a valid slot in the read state to
// read the entry memory and then the eval state to compare. The beat is
// taken in the idle state and the closing result is given in the reply
// state. The single read port of the entry memory is why a valid slot
// needs both states. A tick gives one result beat per expired entry and
// then a scan done beat with last set; set and get give one beat. A held
// output beat stalls the scan only when another result is ready to go. The
// default timeout register may be written while no request is in progress.
// ----------------------------------------------------------------------------
module pending_request_timeout_table #(
  parameter int unsigned TableDepth = prtt_pkg::TABLE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  prtt_req_if.sink   in_i,
  prtt_rsp_if.source out_o,
  prtt_cfg_if.sink   cfg_i
);
  import prtt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  // configuration is always taken
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  // sequencer
  prtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // table storage, compare logic and output register
  prtt_datapath #(
    .TableDepth (TableDepth)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .op_i            (in_i.op),
    .flow_i          (in_i.flow),
    .handle_i        (in_i.handle),
    .entry_start_i   (in_i.entry_start),
    .entry_timeout_i (in_i.entry_timeout),
    .early_enable_i  (in_i.early_enable),
    .now_i           (in_i.now),
    .cfg_we_i        (cfg_i.valid),
    .cfg_data_i      (cfg_i.data),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .code_o          (out_o.code),
    .result_flow_o   (out_o.result_flow),
    .result_handle_o (out_o.result_handle),
    .last_o          (out_o.last)
  );

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the pending request timeout table: a queue-fed
// driver offers set, get and tick beats, a clocked monitor predicts each
// accepted beat against a local table model and checks every result beat
// in order, across phases of idling, stalling and default timeout values
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prtt_pkg::*;

  localparam int          CLK_PERIOD  = 12;
  localparam int          RESET_CYCLES = 7;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          DRAIN_CYCLES = 40;   // a little over the longest request
  localparam int          KEY_POOL    = 20;
  localparam int          MAX_REPORTS = 10;
  localparam int          NUM_PHASES  = 8;
  // op value with no meaning, answered with a plain ok
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] flow;
    logic [31:0] handle;
    logic [31:0] start;
    logic [15:0] timeout;
    logic        early;
    logic [31:0] now;
  } req_item_t;

  typedef struct packed {
    code_e       code;
    logic [31:0] flow;
    logic [31:0] handle;
    logic        last;
  } rsp_beat_t;

  logic clk_i;
  logic rst_ni;

  prtt_req_if req_bus ();
  prtt_rsp_if rsp_bus ();
  prtt_cfg_if cfg_bus ();

  pending_request_timeout_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_bus),
    .out_o  (rsp_bus),
    .cfg_i  (cfg_bus)
  );

  // local copy of the table, updated on every accepted request beat
  logic        tbl_valid [TABLE_DEPTH];
  logic [31:0] tbl_key   [TABLE_DEPTH];
  logic [31:0] tbl_handle[TABLE_DEPTH];
  logic [31:0] tbl_start [TABLE_DEPTH];
  logic [15:0] tbl_limit [TABLE_DEPTH];
  logic        tbl_early [TABLE_DEPTH];
  logic [15:0] tbl_default;

  req_item_t request_q[$];        // beats waiting for the driver
  rsp_beat_t pending_results_q[$]; // result beats predicted, not yet seen

  int unsigned pushed_cnt;
  int unsigned accepted_cnt;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  bit          req_taken;
  bit          cfg_taken;

  // idling knobs, changed only between phases
  int unsigned send_idle_pct;
  int unsigned rcv_stall_pct;

  // long receiver hold-off, requested by the sequence, served by its own process
  int unsigned hold_req_cnt;
  int unsigned hold_served_cnt;
  int unsigned hold_left;

  // stimulus generator state
  logic [31:0] key_pool[KEY_POOL];
  logic [31:0] gen_time;

  int unsigned phase_send[NUM_PHASES] = '{0, 64, 0, 16, 0, 64, 0, 16};
  int unsigned phase_rcv [NUM_PHASES] = '{0, 0, 64, 16, 0, 0, 64, 16};
  int unsigned phase_len [NUM_PHASES] = '{50, 50, 50, 50, 50, 55, 55, 50};
  logic [15:0] phase_cfg [NUM_PHASES] = '{16'd120, 16'd1, 16'd65535, 16'd0,
                                          16'd0, 16'd30, 16'd5, 16'd120};

  // clock
  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  function automatic void queue_result(code_e code, logic [31:0] flow,
                                       logic [31:0] handle, logic last);
    rsp_beat_t beat;
    beat.code   = code;
    beat.flow   = flow;
    beat.handle = handle;
    beat.last   = last;
    pending_results_q.push_back(beat);
  endfunction

  function automatic int find_flow(logic [31:0] flow);
    int hit;
    hit = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit < 0 && tbl_valid[i] && tbl_key[i] == flow) hit = i;
    end
    return hit;
  endfunction

  // apply one request beat to the table copy and queue the beats it causes
  function automatic void predict_table_op(req_item_t it);
    int          slot;
    logic [31:0] elapsed;
    logic [31:0] lim;
    slot = -1;
    case (it.op)
      OP_SET: begin
        slot = find_flow(it.flow);
        // new key: lowest free slot
        if (slot < 0) begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot < 0 && !tbl_valid[i]) slot = i;
          end
        end
        if (slot < 0) begin
          queue_result(CODE_FULL, it.flow, it.handle, 1'b1);
        end else begin
          tbl_valid[slot]  = 1'b1;
          tbl_key[slot]    = it.flow;
          tbl_handle[slot] = it.handle;
          tbl_start[slot]  = it.start;
          tbl_limit[slot]  = (it.timeout == 16'd0) ? tbl_default : it.timeout;
          tbl_early[slot]  = it.early;
          queue_result(CODE_OK, it.flow, it.handle, 1'b1);
        end
      end
      OP_GET: begin
        slot = find_flow(it.flow);
        if (slot < 0) begin
          queue_result(CODE_NOT_FOUND, it.flow, 32'd0, 1'b1);
        end else begin
          tbl_valid[slot] = 1'b0;
          queue_result(CODE_OK, it.flow, tbl_handle[slot], 1'b1);
        end
      end
      OP_TICK: begin
        // slot order scan, elapsed wraps at 32 bits
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (tbl_valid[i]) begin
            elapsed = it.now - tbl_start[i];
            lim     = {16'd0, tbl_limit[i]};
            if (elapsed > (lim << 1)) begin
              queue_result(CODE_TIMED_OUT, tbl_key[i], tbl_handle[i], 1'b0);
              tbl_valid[i] = 1'b0;
            end else if (elapsed > lim && tbl_early[i]) begin
              queue_result(CODE_FORCED, tbl_key[i], tbl_handle[i], 1'b0);
              tbl_valid[i] = 1'b0;
            end
          end
        end
        queue_result(CODE_DONE, 32'd0, 32'd0, 1'b1);
      end
      default: begin
        queue_result(CODE_OK, 32'd0, 32'd0, 1'b1);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // driver, receiver, hold-off
  // --------------------------------------------------------------------------

  // request driver: holds a beat until it is taken, idles at random otherwise
  always @(negedge clk_i) begin : req_driver
    req_item_t it;
    if (rst_ni && (!req_bus.valid || req_taken)) begin
      req_taken = 1'b0;
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = request_q.pop_front();
        req_bus.valid         <= 1'b1;
        req_bus.op            <= it.op;
        req_bus.flow          <= it.flow;
        req_bus.handle        <= it.handle;
        req_bus.entry_start   <= it.start;
        req_bus.entry_timeout <= it.timeout;
        req_bus.early_enable  <= it.early;
        req_bus.now           <= it.now;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // response ready: random stall, forced low during a hold-off
  always @(negedge clk_i) begin : rsp_receiver
    rsp_bus.ready <= rst_ni && (hold_left == 0) && ($urandom_range(99) >= rcv_stall_pct);
  end

  // long hold-off so the output backs up and the block stalls its input
  always @(negedge clk_i) begin : rsp_hold
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req_cnt != hold_served_cnt) begin
      hold_left       <= HOLD_CYCLES;
      hold_served_cnt <= hold_served_cnt + 1;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: every handshake is sampled at the rising edge
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin : beat_monitor
    rsp_beat_t want;
    req_item_t seen;
    if (rst_ni) begin
      // result beat against the oldest prediction
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
        if (pending_results_q.size() == 0) begin
          if (err_cnt < MAX_REPORTS)
            $display({"error: result beat with nothing expected: ",
                      "code %0d flow %h handle %h last %b"},
                     rsp_bus.code, rsp_bus.result_flow, rsp_bus.result_handle, rsp_bus.last);
          err_cnt++;
        end else begin
          want = pending_results_q.pop_front();
          if (rsp_bus.code !== want.code || rsp_bus.result_flow !== want.flow ||
              rsp_bus.result_handle !== want.handle || rsp_bus.last !== want.last) begin
            if (err_cnt < MAX_REPORTS)
              $display({"error: result mismatch: exp code %0d flow %h handle %h last %b, ",
                        "got code %0d flow %h handle %h last %b"},
                       want.code, want.flow, want.handle, want.last, rsp_bus.code,
                       rsp_bus.result_flow, rsp_bus.result_handle, rsp_bus.last);
            err_cnt++;
          end
        end
      end
      // request beat taken: predict what it causes
      if (req_bus.valid && req_bus.ready === 1'b1) begin
        seen.op      = req_bus.op;
        seen.flow    = req_bus.flow;
        seen.handle  = req_bus.handle;
        seen.start   = req_bus.entry_start;
        seen.timeout = req_bus.entry_timeout;
        seen.early   = req_bus.early_enable;
        seen.now     = req_bus.now;
        predict_table_op(seen);
        req_taken = 1'b1;
        accepted_cnt++;
      end
      // default timeout write
      if (cfg_bus.valid && cfg_bus.ready === 1'b1) begin
        tbl_default = cfg_bus.data;
        cfg_taken   = 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------

  // called right after a rising edge, the driver picks it up at the falling one
  function automatic void queue_request(logic [1:0] op, logic [31:0] flow,
                                        logic [31:0] handle, logic [31:0] start,
                                        logic [15:0] timeout, logic early,
                                        logic [31:0] now);
    req_item_t it;
    it.op      = op;
    it.flow    = flow;
    it.handle  = handle;
    it.start   = start;
    it.timeout = timeout;
    it.early   = early;
    it.now     = now;
    request_q.push_back(it);
    pushed_cnt++;
  endfunction

  // sender pause: all beats taken and all results back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (accepted_cnt != pushed_cnt || pending_results_q.size() != 0);
  endtask

  task automatic write_default(logic [15:0] value);
    @(negedge clk_i);
    cfg_taken = 1'b0;
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    do @(negedge clk_i);
    while (!cfg_taken);
    cfg_bus.valid <= 1'b0;
  endtask

  // mostly well-formed traffic on a small key pool with a slowly moving clock
  task automatic run_random_phase(int unsigned count);
    int unsigned pick;
    logic [1:0]  op;
    logic [31:0] flow;
    logic [31:0] start;
    logic [15:0] timeout;
    logic [31:0] now;
    @(posedge clk_i);
    for (int unsigned k = 0; k < count; k++) begin
      pick    = $urandom_range(99);
      flow    = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(KEY_POOL - 1)];
      start   = $urandom;
      timeout = 16'($urandom);
      now     = $urandom;
      if (pick < 40) begin
        op = OP_SET;
        if ($urandom_range(19) != 0) start = gen_time - $urandom_range(10);
        case ($urandom_range(4))
          0:       timeout = 16'd0;
          1:       timeout = 16'($urandom);
          default: timeout = 16'($urandom_range(30, 1));
        endcase
      end else if (pick < 65) begin
        op = OP_GET;
      end else if (pick < 95) begin
        op = OP_TICK;
        gen_time = gen_time + $urandom_range(12);
        if ($urandom_range(19) != 0) now = gen_time + $urandom_range(3);
      end else begin
        op = OP_UNUSED;
      end
      queue_request(op, flow, $urandom, start, timeout, 1'($urandom_range(1)), now);
    end
  endtask

  initial begin : sequence_main
    // known levels on every input from time zero
    rst_ni                = 1'b0;
    req_bus.valid         = 1'b0;
    req_bus.op            = OP_SET;
    req_bus.flow          = '0;
    req_bus.handle        = '0;
    req_bus.entry_start   = '0;
    req_bus.entry_timeout = '0;
    req_bus.early_enable  = 1'b0;
    req_bus.now           = '0;
    rsp_bus.ready         = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.data          = '0;
    send_idle_pct         = 0;
    rcv_stall_pct         = 0;
    hold_req_cnt          = 0;
    hold_served_cnt       = 0;
    hold_left             = 0;
    pushed_cnt            = 0;
    accepted_cnt          = 0;
    err_cnt               = 0;
    cycle_cnt             = 0;
    req_taken             = 1'b0;
    cfg_taken             = 1'b0;
    tbl_default           = RESET_TIMEOUT;
    for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;

    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    // starts just below the wrap so the random clock rolls over
    gen_time     = 32'hFFFF_FE00;
    phase_cfg[4] = 16'($urandom_range(65535, 1));

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed beats at the reset default timeout
    @(posedge clk_i);
    // tick on an empty table gives only the closing beat
    queue_request(OP_TICK, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0, 32'h0);
    // zero timeout takes the default
    queue_request(OP_SET, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0, 32'h0);
    queue_request(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 16'hFFFF, 1'b1,
                  32'hFFFF_FFFF);
    // same key again overwrites in place
    queue_request(OP_SET, 32'h0, 32'hAAAA_5555, 32'd100, 16'd10, 1'b1, 32'h0);
    queue_request(OP_GET, 32'h0001_2345, 32'h0, 32'h0, 16'h0, 1'b0, 32'h0);
    queue_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                  32'hFFFF_FFFF);
    // fill the remaining slots
    for (int i = 0; i < TABLE_DEPTH - 2; i++)
      queue_request(OP_SET, 32'h100 + i, 32'h5A00 + i, 32'd200, 16'd5, i[0], 32'h0);
    // full table: new key refused, known key still replaced
    queue_request(OP_SET, 32'hDEAD_BEEF, 32'h1111_2222, 32'd0, 16'd1, 1'b0, 32'h0);
    queue_request(OP_SET, 32'h100, 32'h3333_4444, 32'd200, 16'd5, 1'b0, 32'h0);
    // elapsed equal to twice the limit only force-finishes the early fill entries,
    // key 0 times out, and the entry started just below the wrap is still young
    queue_request(OP_TICK, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0, 32'd210);
    queue_request(OP_TICK, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0, 32'd211);
    queue_request(OP_GET, 32'hFFFF_FFFF, 32'h0, 32'h0, 16'h0, 1'b0, 32'h0);
    queue_request(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                  32'hFFFF_FFFF);
    wait_drained();

    // random phases, each with its own default timeout and idling mix
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_default(phase_cfg[p]);
      @(posedge clk_i);
      send_idle_pct = phase_send[p];
      rcv_stall_pct = phase_rcv[p];
      // one long receiver hold-off while the sender keeps offering
      if (p == 2) hold_req_cnt = hold_req_cnt + 1;
      run_random_phase(phase_len[p]);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (err_cnt == 0 && pending_results_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/prtt_pkg.sv
rtl/core/prtt_if.sv
rtl/core/prtt_datapath.sv
rtl/core/prtt_ctrl.sv
rtl/core/pending_request_timeout_table.sv
dv/tb.sv
